>>> hdl/rihf_pkg.sv
// shared constants, types and the reciprocal table for the range image hole filler
package rihf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int RING        = MAX_WIDTH + 2;
  localparam int PTR_BITS    = $clog2(RING);
  localparam int DIST_BITS   = 16;
  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int ROW_BITS    = 12;
  localparam int COL_BITS    = 11;
  localparam int CNT_BITS    = 4;
  localparam int SUM_BITS    = 20;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN  = WIDTH_BITS'(3);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX  = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN = HEIGHT_BITS'(3);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = HEIGHT_BITS'(MAX_HEIGHT);

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET        = WIDTH_BITS'(1024);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET       = HEIGHT_BITS'(64);
  localparam logic [DIST_BITS-1:0]   HOLE_HIGH_RESET    = DIST_BITS'(23040);
  localparam logic [DIST_BITS-1:0]   HOLE_LOW_RESET     = DIST_BITS'(26);
  localparam logic [DIST_BITS-1:0]   VALID_FLOOR_RESET  = DIST_BITS'(0);
  localparam logic [DIST_BITS-1:0]   SPREAD_LIMIT_RESET = DIST_BITS'(512);
  localparam logic [CNT_BITS-1:0]    MIN_COUNT_RESET    = CNT_BITS'(6);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLE_HIGH    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLE_LOW     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VALID_FLOOR  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPREAD_LIMIT = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_COUNT    = 3'd6;

  // window read steps: centre, right, below left, below, below right
  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] STEP_C  = 3'd0;
  localparam logic [STEP_BITS-1:0] STEP_R  = 3'd1;
  localparam logic [STEP_BITS-1:0] STEP_BL = 3'd2;
  localparam logic [STEP_BITS-1:0] STEP_B  = 3'd3;
  localparam logic [STEP_BITS-1:0] STEP_BR = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // ring position of an entry a given age behind the write pointer
  function automatic logic [PTR_BITS-1:0] ring_addr(input logic [PTR_BITS-1:0] wp,
                                                    input logic [PTR_BITS-1:0] age);
    logic [PTR_BITS:0] s;
    s = {1'b0, wp} + (PTR_BITS+1)'(RING) - {1'b0, age};
    if (s >= (PTR_BITS+1)'(RING)) begin
      s = s - (PTR_BITS+1)'(RING);
    end
    return s[PTR_BITS-1:0];
  endfunction

  // ring pointer advance with wrap
  function automatic logic [PTR_BITS-1:0] ring_inc(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] r;
    if (p == PTR_BITS'(RING - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_BITS'(1);
    end
    return r;
  endfunction

  // ceil(2^24 / d), exact truncating quotient for sums below 2^20
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] d);
    logic [RECIP_BITS-1:0] r;
    case (d)
      4'd1:    r = RECIP_BITS'(16777216);
      4'd2:    r = RECIP_BITS'(8388608);
      4'd3:    r = RECIP_BITS'(5592406);
      4'd4:    r = RECIP_BITS'(4194304);
      4'd5:    r = RECIP_BITS'(3355444);
      4'd6:    r = RECIP_BITS'(2796203);
      4'd7:    r = RECIP_BITS'(2396746);
      4'd8:    r = RECIP_BITS'(2097152);
      4'd9:    r = RECIP_BITS'(1864136);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/range_image_hole_fill_3x3_core.sv
// range image hole filler: line rings in memory, 3x3 window gathered by sequenced reads
//
//  channel | direction | handshake           | payload
//  src     | in        | src_valid/src_stall | distance, flush
//  dst     | out       | dst_valid/dst_stall | filled_distance, was_filled, frame_last
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one transaction in flight at a time; an item that emits nothing leaves the core idle
// a border, non-hole or flush pixel reads only the centre before it is emitted; a hole pixel
// takes five reads through the single read port of the raw ring, one multiply and one emit
// reset clears control and loads the configuration defaults; ring contents are undefined until written
// a stalled output is held in its register; a new item is taken meanwhile
module range_image_hole_fill_3x3_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  logic [rihf_pkg::DIST_BITS-1:0]      distance,
  input  logic                                flush,
  output logic                                dst_valid,
  input  logic                                dst_stall,
  output logic [rihf_pkg::DIST_BITS-1:0]      filled_distance,
  output logic                                was_filled,
  output logic                                frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rihf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rihf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DB = rihf_pkg::DIST_BITS;
  localparam int PB = rihf_pkg::PTR_BITS;
  localparam int WB = rihf_pkg::WIDTH_BITS;
  localparam int HB = rihf_pkg::HEIGHT_BITS;
  localparam int SB = rihf_pkg::SUM_BITS;
  localparam int CB = rihf_pkg::CNT_BITS;
  localparam int RB = rihf_pkg::RECIP_BITS;
  localparam int PRB = SB + RB;

  rihf_pkg::state_t state;

  logic [WB-1:0] image_width;
  logic [HB-1:0] image_height;
  logic [DB-1:0] hole_high;
  logic [DB-1:0] hole_low;
  logic [DB-1:0] valid_floor;
  logic [DB-1:0] spread_limit;
  logic [CB-1:0] min_count;

  logic [WB-1:0] eff_w;
  logic [HB-1:0] eff_h;

  logic [DB-1:0] raw_mem    [rihf_pkg::RING];
  logic [DB-1:0] filled_mem [rihf_pkg::RING];
  logic [DB-1:0] raw_q;
  logic [DB-1:0] filled_q;
  logic [PB-1:0] raw_wp;
  logic [PB-1:0] filled_wp;
  logic [PB-1:0] raw_wp_next;
  logic [PB-1:0] filled_wp_next;
  logic [PB-1:0] raw_ra;
  logic [PB-1:0] filled_ra;
  logic          raw_we;
  logic          filled_we;

  logic [PB-1:0] pending;
  logic [PB-1:0] c0;
  logic          is_flush;
  logic [DB-1:0] left_filled;
  logic [rihf_pkg::ROW_BITS-1:0] row;
  logic [rihf_pkg::COL_BITS-1:0] col;

  logic [rihf_pkg::STEP_BITS-1:0] rd_step;
  logic [rihf_pkg::STEP_BITS-1:0] proc_step;
  logic          proc_valid;
  logic          issue;

  logic [DB-1:0] centre;
  logic [CB-1:0] cnt;
  logic [SB-1:0] sum;
  logic [DB-1:0] mn;
  logic [DB-1:0] mx;
  logic [DB-1:0] mean;
  logic          use_mean;

  logic          src_acc;
  logic          cfg_we;
  logic          emit_go;
  logic          interior;
  logic          last_pos;
  logic          hole;
  logic          fill_ok;
  logic [HB-1:0] row_inc;
  logic [WB-1:0] col_inc;
  logic [HB-1:0] age_raw;
  logic [WB-1:0] age_filled;
  logic [DB-1:0] val_b;
  logic          use_b;
  logic          va;
  logic          vb;
  logic [CB-1:0] cnt_n;
  logic [SB-1:0] sum_n;
  logic [DB-1:0] mn_a;
  logic [DB-1:0] mx_a;
  logic [DB-1:0] mn_n;
  logic [DB-1:0] mx_n;
  logic [PRB-1:0] prod_c;
  logic [DB-1:0] emit_val;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign src_stall = (state != rihf_pkg::ST_IDLE);
  assign src_acc   = src_valid && !src_stall;
  assign emit_go   = (state == rihf_pkg::ST_EMIT) && (!dst_valid || !dst_stall);

  always_comb begin
    if (image_width < rihf_pkg::WIDTH_MIN) begin
      eff_w = rihf_pkg::WIDTH_MIN;
    end else if (image_width > rihf_pkg::WIDTH_MAX) begin
      eff_w = rihf_pkg::WIDTH_MAX;
    end else begin
      eff_w = image_width;
    end
    if (image_height < rihf_pkg::HEIGHT_MIN) begin
      eff_h = rihf_pkg::HEIGHT_MIN;
    end else if (image_height > rihf_pkg::HEIGHT_MAX) begin
      eff_h = rihf_pkg::HEIGHT_MAX;
    end else begin
      eff_h = image_height;
    end
  end

  // position of the next output pixel
  assign row_inc  = {1'b0, row} + HB'(1);
  assign col_inc  = {1'b0, col} + WB'(1);
  assign interior = (row != '0) && (row_inc < eff_h) && (col != '0) && (col_inc < eff_w);
  assign last_pos = (row_inc >= eff_h) && (col_inc >= eff_w);

  // ring addressing
  assign raw_wp_next    = rihf_pkg::ring_inc(raw_wp);
  assign filled_wp_next = rihf_pkg::ring_inc(filled_wp);
  assign raw_we         = src_acc && !flush;
  assign filled_we      = emit_go;
  assign issue          = (state == rihf_pkg::ST_READ) && (rd_step <= rihf_pkg::STEP_BR);

  always_comb begin
    case (rd_step)
      rihf_pkg::STEP_C:  age_raw = {1'b0, c0};
      rihf_pkg::STEP_R:  age_raw = {1'b0, c0} - HB'(1);
      rihf_pkg::STEP_BL: age_raw = {1'b0, c0} - {1'b0, eff_w} + HB'(1);
      rihf_pkg::STEP_B:  age_raw = {1'b0, c0} - {1'b0, eff_w};
      rihf_pkg::STEP_BR: age_raw = {1'b0, c0} - {1'b0, eff_w} - HB'(1);
      default:           age_raw = {1'b0, c0};
    endcase
    case (rd_step)
      rihf_pkg::STEP_C:  age_filled = eff_w;
      rihf_pkg::STEP_R:  age_filled = eff_w - WB'(1);
      rihf_pkg::STEP_BL: age_filled = eff_w - WB'(2);
      default:           age_filled = eff_w;
    endcase
  end

  assign raw_ra    = rihf_pkg::ring_addr(raw_wp, age_raw[PB-1:0]);
  assign filled_ra = rihf_pkg::ring_addr(filled_wp, age_filled[PB-1:0]);

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[raw_wp_next] <= distance;
    end
    raw_q <= raw_mem[raw_ra];
  end

  always_ff @(posedge clk) begin
    if (filled_we) begin
      filled_mem[filled_wp_next] <= emit_val;
    end
    filled_q <= filled_mem[filled_ra];
  end

  // window accumulation, two values per read but one at the below-right step
  always_comb begin
    case (proc_step)
      rihf_pkg::STEP_C:  val_b = filled_q;
      rihf_pkg::STEP_R:  val_b = filled_q;
      rihf_pkg::STEP_BL: val_b = filled_q;
      rihf_pkg::STEP_B:  val_b = left_filled;
      default:           val_b = filled_q;
    endcase
    use_b = (proc_step != rihf_pkg::STEP_BR);
    va    = (raw_q < hole_high) && (raw_q > valid_floor);
    vb    = use_b && (val_b < hole_high) && (val_b > valid_floor);
    cnt_n = cnt + CB'(va) + CB'(vb);
    sum_n = sum + (va ? SB'(raw_q) : '0) + (vb ? SB'(val_b) : '0);
    mn_a  = (va && raw_q < mn) ? raw_q : mn;
    mx_a  = (va && raw_q > mx) ? raw_q : mx;
    mn_n  = (vb && val_b < mn_a) ? val_b : mn_a;
    mx_n  = (vb && val_b > mx_a) ? val_b : mx_a;
  end

  assign hole    = (raw_q > hole_high) || (raw_q < hole_low);
  assign fill_ok = (cnt != '0) && (cnt >= min_count) && ((mx - mn) < spread_limit);
  assign prod_c  = {{RB{1'b0}}, sum} * {{SB{1'b0}}, rihf_pkg::recip(cnt)};
  assign emit_val = use_mean ? mean : centre;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rihf_pkg::ST_IDLE;
      image_width  <= rihf_pkg::WIDTH_RESET;
      image_height <= rihf_pkg::HEIGHT_RESET;
      hole_high    <= rihf_pkg::HOLE_HIGH_RESET;
      hole_low     <= rihf_pkg::HOLE_LOW_RESET;
      valid_floor  <= rihf_pkg::VALID_FLOOR_RESET;
      spread_limit <= rihf_pkg::SPREAD_LIMIT_RESET;
      min_count    <= rihf_pkg::MIN_COUNT_RESET;
      raw_wp       <= '0;
      filled_wp    <= '0;
      pending      <= '0;
      left_filled  <= '0;
      row          <= '0;
      col          <= '0;
      rd_step      <= '0;
      proc_valid   <= 1'b0;
      dst_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rihf_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WB-1:0];
          rihf_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[HB-1:0];
          rihf_pkg::CFG_HOLE_HIGH:    hole_high    <= cfg_data[DB-1:0];
          rihf_pkg::CFG_HOLE_LOW:     hole_low     <= cfg_data[DB-1:0];
          rihf_pkg::CFG_VALID_FLOOR:  valid_floor  <= cfg_data[DB-1:0];
          rihf_pkg::CFG_SPREAD_LIMIT: spread_limit <= cfg_data[DB-1:0];
          rihf_pkg::CFG_MIN_COUNT:    min_count    <= cfg_data[CB-1:0];
          default: ;
        endcase
      end

      proc_valid <= issue;
      if (issue) begin
        rd_step <= rd_step + rihf_pkg::STEP_BITS'(1);
      end

      if (dst_valid && !dst_stall && !emit_go) begin
        dst_valid <= 1'b0;
      end

      case (state)
        rihf_pkg::ST_IDLE: begin
          rd_step <= rihf_pkg::STEP_C;
          if (src_acc) begin
            if (flush) begin
              if (pending != '0) begin
                pending <= pending - PB'(1);
                state   <= rihf_pkg::ST_READ;
              end
            end else begin
              raw_wp <= raw_wp_next;
              if ({1'b0, pending} <= (PB+1)'(eff_w)) begin
                pending <= pending + PB'(1);
              end else begin
                state <= rihf_pkg::ST_READ;
              end
            end
          end
        end
        rihf_pkg::ST_READ: begin
          if (proc_valid) begin
            if (proc_step == rihf_pkg::STEP_C) begin
              if (is_flush || !interior || !hole) begin
                state <= rihf_pkg::ST_EMIT;
              end
            end else if (proc_step == rihf_pkg::STEP_BR) begin
              state <= rihf_pkg::ST_MUL;
            end
          end
        end
        rihf_pkg::ST_MUL: begin
          state <= rihf_pkg::ST_EMIT;
        end
        rihf_pkg::ST_EMIT: begin
          if (emit_go) begin
            dst_valid   <= 1'b1;
            filled_wp   <= filled_wp_next;
            left_filled <= emit_val;
            if (col_inc >= eff_w) begin
              col <= '0;
              if (row_inc >= eff_h) begin
                row <= '0;
              end else begin
                row <= row_inc[rihf_pkg::ROW_BITS-1:0];
              end
            end else begin
              col <= col_inc[rihf_pkg::COL_BITS-1:0];
            end
            state <= rihf_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rihf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    proc_step <= rd_step;
    if (src_acc) begin
      is_flush <= flush;
      c0       <= flush ? pending - PB'(1) : pending;
      use_mean <= 1'b0;
      cnt      <= '0;
      sum      <= '0;
      mn       <= '1;
      mx       <= '0;
    end
    if (state == rihf_pkg::ST_READ && proc_valid) begin
      cnt <= cnt_n;
      sum <= sum_n;
      mn  <= mn_n;
      mx  <= mx_n;
      if (proc_step == rihf_pkg::STEP_C) begin
        centre <= raw_q;
      end
    end
    if (state == rihf_pkg::ST_MUL) begin
      mean     <= prod_c[rihf_pkg::RECIP_SHIFT +: DB];
      use_mean <= fill_ok;
    end
    if (emit_go) begin
      filled_distance <= emit_val;
      was_filled      <= use_mean;
      frame_last      <= last_pos;
    end
  end

  // a result appears only from the emit state
  assert property (@(posedge clk) disable iff (rst)
    $rose(dst_valid) |-> $past(state == rihf_pkg::ST_EMIT))
    else $error("result without emit");

  // a flush with nothing pending produces no work
  assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall && flush && pending == '0) |=> state == rihf_pkg::ST_IDLE)
    else $error("empty flush started work");

  // a filled pixel is never on the border, so never the last of a frame
  assert property (@(posedge clk) disable iff (rst)
    (dst_valid && was_filled) |-> !frame_last)
    else $error("filled pixel marked as frame end");

  // the pending count never exceeds the ring
  assert property (@(posedge clk) disable iff (rst)
    src_acc && !flush |=> pending <= PB'(rihf_pkg::RING - 1))
    else $error("pending count beyond ring");

endmodule
